// ----- rtl/chacha_rng_pkg.sv -----
// Package for the ChaCha random word generator: payload types, action codes,
// sequencer states and ChaCha constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chacha_rng_pkg;

  localparam int unsigned NWORDS = 16;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_MIX  = 2'd1,
    ACT_GEN  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] noise_reg;
    logic [11:0] adc_sample;
    logic [23:0] timer_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        not_ready;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_t;

  localparam logic [1:0] CFG_UID_LOW  = 2'd0;
  localparam logic [1:0] CFG_UID_MID  = 2'd1;
  localparam logic [1:0] CFG_UID_HIGH = 2'd2;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam int unsigned MIX_ROT = 13;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] quad_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/chacha_rng_qr.sv -----
// Four parallel ChaCha quarter-round units; one full round per call.
// Depends on chacha_rng_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chacha_rng_qr (
  input  wire  chacha_rng_pkg::quad_t a,
  input  wire  chacha_rng_pkg::quad_t b,
  input  wire  chacha_rng_pkg::quad_t c,
  input  wire  chacha_rng_pkg::quad_t d,
  output chacha_rng_pkg::quad_t       ao,
  output chacha_rng_pkg::quad_t       bo,
  output chacha_rng_pkg::quad_t       co,
  output chacha_rng_pkg::quad_t       dout
);
  always_comb begin
    logic [31:0] ta, tb, tc, td;
    for (int i = 0; i < 4; i++) begin
      ta = a[i] + b[i];
      td = chacha_rng_pkg::rotl(d[i] ^ ta, 16);
      tc = c[i] + td;
      tb = chacha_rng_pkg::rotl(b[i] ^ tc, 12);
      ta = ta + tb;
      td = chacha_rng_pkg::rotl(td ^ ta, 8);
      tc = tc + td;
      tb = chacha_rng_pkg::rotl(tb ^ tc, 7);
      ao[i] = ta;
      bo[i] = tb;
      co[i] = tc;
      dout[i] = td;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/chacha_entropy_mixing_rng.sv -----
// ChaCha random word generator with entropy mixing; top level.
// Init, mix and unused actions are accepted back to back.
// Generate: ROUNDS rounds in the shared quarter-round unit (ST_ROUND), then
// feed-forward, key copy and mix in ST_FINISH; the word is offered in ST_OUT,
// next word accepted the cycle after it leaves (unseeded: straight to ST_OUT).
// Sync reset clears state words, uid and seeded, pointer to 4. Needs pkg and qr.
`timescale 1ns / 1ps
`default_nettype none
module chacha_entropy_mixing_rng #(
  parameter int unsigned ROUNDS = 20
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  chacha_rng_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output chacha_rng_pkg::out_word_t out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [1:0]                cfg_index,
  input  wire  [31:0]               cfg_data
);
  localparam int unsigned RW = $clog2(ROUNDS + 1);

  chacha_rng_pkg::state_t state, state_next;
  logic [31:0] cw [16];
  logic [31:0] wk [16];
  logic [31:0] uid [3];
  logic [3:0]  mix_pointer;
  logic        seeded;
  logic [RW-1:0] rnd;
  logic [31:0] entropy, ent_hold;
  chacha_rng_pkg::quad_t qa, qb, qc, qd, ra, rb, rc, rd;
  logic odd;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != chacha_rng_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign entropy   = {16'd0, in_data.noise_reg} ^ {4'd0, in_data.adc_sample, 16'd0}
                   ^ {8'd0, in_data.timer_value};
  assign odd = rnd[0];
  assign out_valid = (state == chacha_rng_pkg::ST_OUT);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qa[i] = wk[i];
      qb[i] = odd ? wk[4 + ((i + 1) % 4)]  : wk[4 + i];
      qc[i] = odd ? wk[8 + ((i + 2) % 4)]  : wk[8 + i];
      qd[i] = odd ? wk[12 + ((i + 3) % 4)] : wk[12 + i];
    end
  end

  chacha_rng_qr u_qr (.a(qa), .b(qb), .c(qc), .d(qd), .ao(ra), .bo(rb), .co(rc), .dout(rd));

  always_comb begin
    state_next = state;
    unique case (state)
      chacha_rng_pkg::ST_IDLE: begin
        if (in_acc && in_data.action == chacha_rng_pkg::ACT_GEN) begin
          state_next = seeded ? chacha_rng_pkg::ST_ROUND : chacha_rng_pkg::ST_OUT;
        end
      end
      chacha_rng_pkg::ST_ROUND: begin
        if (rnd == RW'(ROUNDS - 1)) state_next = chacha_rng_pkg::ST_FINISH;
      end
      chacha_rng_pkg::ST_FINISH: state_next = chacha_rng_pkg::ST_OUT;
      chacha_rng_pkg::ST_OUT: begin
        if (!out_stall) state_next = chacha_rng_pkg::ST_IDLE;
      end
      default: state_next = chacha_rng_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chacha_rng_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [3:0] p;
    logic [31:0] sum;
    if (rst) begin
      for (int i = 0; i < 16; i++) cw[i] <= '0;
      for (int i = 0; i < 3; i++) uid[i] <= '0;
      mix_pointer <= 4'd4;
      seeded <= 1'b0;
      rnd <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          chacha_rng_pkg::CFG_UID_LOW:  uid[0] <= cfg_data;
          chacha_rng_pkg::CFG_UID_MID:  uid[1] <= cfg_data;
          chacha_rng_pkg::CFG_UID_HIGH: uid[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        chacha_rng_pkg::ST_IDLE: begin
          rnd <= '0;
          ent_hold <= entropy;
          for (int i = 0; i < 16; i++) wk[i] <= cw[i];
          if (in_acc) begin
            unique case (in_data.action)
              chacha_rng_pkg::ACT_INIT: begin
                cw[0] <= chacha_rng_pkg::SIGMA0;
                cw[1] <= chacha_rng_pkg::SIGMA1;
                cw[2] <= chacha_rng_pkg::SIGMA2;
                cw[3] <= chacha_rng_pkg::SIGMA3;
                for (int i = 0; i < 3; i++) cw[4 + i] <= uid[i];
                for (int i = 7; i < 16; i++) cw[i] <= entropy;
                seeded <= 1'b1;
              end
              chacha_rng_pkg::ACT_MIX: begin
                cw[mix_pointer] <= chacha_rng_pkg::rotl(cw[mix_pointer] ^ entropy,
                                                        chacha_rng_pkg::MIX_ROT);
                mix_pointer <= (mix_pointer == 4'd11) ? 4'd4 : mix_pointer + 4'd1;
              end
              chacha_rng_pkg::ACT_GEN: begin
                out_data.random_word <= '0;
                out_data.not_ready <= !seeded;
              end
              default: ;
            endcase
          end
        end
        chacha_rng_pkg::ST_ROUND: begin
          rnd <= rnd + RW'(1);
          for (int i = 0; i < 4; i++) begin
            wk[i] <= ra[i];
            if (odd) begin
              wk[4 + ((i + 1) % 4)]  <= rb[i];
              wk[8 + ((i + 2) % 4)]  <= rc[i];
              wk[12 + ((i + 3) % 4)] <= rd[i];
            end else begin
              wk[4 + i]  <= rb[i];
              wk[8 + i]  <= rc[i];
              wk[12 + i] <= rd[i];
            end
          end
        end
        chacha_rng_pkg::ST_FINISH: begin
          out_data.random_word <= wk[0] + cw[0];
          p = mix_pointer;
          for (int i = 4; i < 12; i++) begin
            sum = wk[i] + cw[i];
            if (p == 4'(i)) begin
              cw[i] <= chacha_rng_pkg::rotl(sum ^ ent_hold, chacha_rng_pkg::MIX_ROT);
            end else begin
              cw[i] <= sum;
            end
          end
          cw[12] <= cw[12] + 32'd1;
          mix_pointer <= (mix_pointer == 4'd11) ? 4'd4 : mix_pointer + 4'd1;
        end
        chacha_rng_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != chacha_rng_pkg::ST_IDLE) |-> in_stall)
    else $error("input not stalled while busy");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (mix_pointer >= 4'd4) && (mix_pointer <= 4'd11))
    else $error("mix pointer out of key range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.not_ready) |-> (out_data.random_word == 32'd0))
    else $error("error result carries data");
endmodule
`default_nettype wire

// ----- tb/tb_chacha_entropy_mixing_rng.sv -----
// Testbench for chacha_entropy_mixing_rng: directed table then random words,
// checked against a behavioral ChaCha generator model. Depends on chacha_rng_pkg and chacha_entropy_mixing_rng.
`timescale 1ns / 1ps
module tb_chacha_entropy_mixing_rng;

  localparam int ROUNDS = 20;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  chacha_rng_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  chacha_rng_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  chacha_entropy_mixing_rng #(.ROUNDS(ROUNDS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] m_words [16];
  logic [3:0] m_ptr;
  logic m_seeded;
  logic [31:0] m_uid [3];
  chacha_rng_pkg::out_word_t rng_expected [$];
  int errors = 0;
  int quiet = 0;
  bit stall_en = 1'b1;
  bit hold_rx = 1'b0;

  typedef struct {
    chacha_rng_pkg::in_word_t w;
    bit known;
    chacha_rng_pkg::out_word_t res;
  } row_t;
  row_t dir_rows [$];

  function automatic logic [31:0] rl(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void qr(ref logic [31:0] x [16], input int a, b, c, d);
    x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 16);
    x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 12);
    x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 8);
    x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 7);
  endfunction

  function automatic void mix_entropy(logic [31:0] e);
    logic [3:0] p;
    p = (m_ptr < 4 || m_ptr > 11) ? 4'd4 : m_ptr;
    m_words[p] = rl(m_words[p] ^ e, chacha_rng_pkg::MIX_ROT);
    m_ptr = (p == 11) ? 4'd4 : p + 4'd1;
  endfunction

  function automatic void predict_rng(chacha_rng_pkg::in_word_t w);
    logic [31:0] e;
    logic [31:0] x [16];
    chacha_rng_pkg::out_word_t r;
    e = {16'h0, w.noise_reg} ^ ({20'h0, w.adc_sample} << 16) ^ {8'h0, w.timer_value};
    case (chacha_rng_pkg::action_t'(w.action))
      chacha_rng_pkg::ACT_INIT: begin
        m_words[0] = chacha_rng_pkg::SIGMA0; m_words[1] = chacha_rng_pkg::SIGMA1;
        m_words[2] = chacha_rng_pkg::SIGMA2; m_words[3] = chacha_rng_pkg::SIGMA3;
        for (int i = 0; i < 3; i++) m_words[4 + i] = m_uid[i];
        for (int i = 7; i < 16; i++) m_words[i] = e;
        m_seeded = 1'b1;
      end
      chacha_rng_pkg::ACT_MIX: mix_entropy(e);
      chacha_rng_pkg::ACT_GEN: begin
        if (!m_seeded) begin
          r.random_word = '0; r.not_ready = 1'b1;
        end else begin
          x = m_words;
          for (int k = 0; k < ROUNDS; k++) begin
            if (k % 2 == 0) begin
              qr(x, 0, 4, 8, 12); qr(x, 1, 5, 9, 13);
              qr(x, 2, 6, 10, 14); qr(x, 3, 7, 11, 15);
            end else begin
              qr(x, 0, 5, 10, 15); qr(x, 1, 6, 11, 12);
              qr(x, 2, 7, 8, 13); qr(x, 3, 4, 9, 14);
            end
          end
          for (int i = 0; i < 16; i++) x[i] += m_words[i];
          for (int i = 4; i < 12; i++) m_words[i] = x[i];
          m_words[12] += 1;
          mix_entropy(e);
          r.random_word = x[0]; r.not_ready = 1'b0;
        end
        rng_expected.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_rng(in_data);
    if (!rst && out_valid && !out_stall) begin
      if (rng_expected.size() == 0) begin
        report_mismatch("unexpected word", out_data.random_word, 0);
      end else begin
        chacha_rng_pkg::out_word_t r;
        r = rng_expected.pop_front();
        if (out_data.random_word !== r.random_word)
          report_mismatch("random_word", out_data.random_word, r.random_word);
        if (out_data.not_ready !== r.not_ready)
          report_mismatch("not_ready", out_data.not_ready, r.not_ready);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("[chacha_entropy_mixing_rng] ERROR");
      $finish;
    end
  end

  // receiver stall process
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 300; i++) @(negedge clk);
        hold_rx = 1'b0;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    m_uid[idx] = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (rng_expected.size() != 0) @(negedge clk);
    repeat (ROUNDS + 8) @(negedge clk);
  endtask

  task automatic send_word(chacha_rng_pkg::in_word_t w, bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1; in_data <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic chacha_rng_pkg::in_word_t rand_word(logic [1:0] act);
    chacha_rng_pkg::in_word_t w;
    w.action = act;
    w.noise_reg = 16'($urandom);
    w.adc_sample = 12'($urandom);
    w.timer_value = 24'($urandom);
    return w;
  endfunction

  function automatic void add_row(logic [1:0] a, logic [15:0] n, logic [11:0] c,
                                  logic [23:0] t, bit k, logic [31:0] rw, bit nr);
    row_t r;
    r.w = '{a, n, c, t}; r.known = k; r.res = '{rw, nr};
    dir_rows.push_back(r);
  endfunction

  initial begin
    logic [1:0] act;
    for (int i = 0; i < 16; i++) m_words[i] = '0;
    m_ptr = 4'd4; m_seeded = 1'b0;
    for (int i = 0; i < 3; i++) m_uid[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_row(chacha_rng_pkg::ACT_GEN, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 1, 32'h0, 1);
    add_row(chacha_rng_pkg::ACT_MIX, 16'h1234, 12'h0, 24'h0, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_NONE, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_GEN, 16'h0, 12'h0, 24'h0, 1, 32'h0, 1);
    add_row(chacha_rng_pkg::ACT_INIT, 16'h0, 12'h0, 24'h0, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_GEN, 16'h0, 12'h0, 24'h0, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      add_row(chacha_rng_pkg::ACT_MIX, 16'hFFFF, 12'hFFF, 24'h0, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_GEN, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_INIT, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_GEN, 16'hA5A5, 12'h5A5, 24'h00FF00, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_NONE, 16'h0, 12'h0, 24'h0, 0, 0, 0);
    add_row(chacha_rng_pkg::ACT_GEN, 16'h0, 12'h0, 24'h0, 0, 0, 0);

    write_reg(chacha_rng_pkg::CFG_UID_LOW, 32'hFFFFFFFF);
    write_reg(chacha_rng_pkg::CFG_UID_MID, 32'h0);
    write_reg(chacha_rng_pkg::CFG_UID_HIGH, 32'hFFFFFFFF);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, 1);
      if (dir_rows[i].known && rng_expected.size() != 0 &&
          rng_expected[$] !== dir_rows[i].res)
        report_mismatch("table row", rng_expected[$].random_word,
                        dir_rows[i].res.random_word);
    end
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(chacha_rng_pkg::CFG_UID_LOW, ph == 1 ? 32'h0 : $urandom);
      write_reg(chacha_rng_pkg::CFG_UID_MID, ph == 1 ? 32'hFFFFFFFF : $urandom);
      write_reg(chacha_rng_pkg::CFG_UID_HIGH, ph == 1 ? 32'h0 : $urandom);
      if (ph == 3) stall_en = 1'b0;
      if (ph == 1) hold_rx = 1'b1;
      send_word(rand_word(chacha_rng_pkg::ACT_INIT), ph != 3);
      for (int i = 0; i < 108; i++) begin
        case ($urandom_range(0, 19))
          0: act = chacha_rng_pkg::ACT_INIT;
          1: act = chacha_rng_pkg::ACT_NONE;
          2, 3, 4, 5, 6: act = chacha_rng_pkg::ACT_MIX;
          default: act = chacha_rng_pkg::ACT_GEN;
        endcase
        send_word(rand_word(act), ph != 3);
        if (ph == 2 && i == 50) begin
          in_valid <= 1'b0;
          while (rng_expected.size() != 0) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0)
      $display("[chacha_entropy_mixing_rng] OK");
    else
      $display("[chacha_entropy_mixing_rng] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/chacha_rng_pkg.sv
rtl/chacha_rng_qr.sv
rtl/chacha_entropy_mixing_rng.sv
tb/tb_chacha_entropy_mixing_rng.sv
